// ----- design/damage_attribution_table_unit_assert.svh -----
`ifndef DAMAGE_ATTRIBUTION_TABLE_UNIT_ASSERT_SVH
`define DAMAGE_ATTRIBUTION_TABLE_UNIT_ASSERT_SVH

// plain check on clk, off during reset
`define DAT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define DAT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DAT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/dat_pkg.sv -----
package dat_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam logic [31:0] WINDOW_RESET = 32'd60;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [31:0] creature_id;
    logic [31:0] amount;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [31:0] found_amount;
    logic [31:0] top_attacker_id;
    logic [31:0] total_amount;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_TREE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic match;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// ----- design/dat_intf.sv -----
interface dat_req_if;
  import dat_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dat_rsp_if;
  import dat_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/damage_attribution_table_unit.sv -----
// damage attribution table
// req channel (sink): one item per request, req_type add or lookup, with
// creature_id, amount and now. rsp channel (source): one item per request
// with found_amount, top_attacker_id and total_amount, all after the update.
// cfg_we / cfg_wdata write the recent-attacker window in rounds.
// an item runs match, update, a registered max tree of log2(ENTRIES) levels
// plus a leaf stage, then loads the output register; the next item is taken
// only after that load, so items do not overlap, and their spacing is set by
// the depth of the max tree over the entries.
// the output register holds a result while rsp.ready is low; the next item is
// accepted meanwhile and waits before its load until the register is free.
// reset clears all entries, the replace pointer and the total, and sets the
// window to 60.
module damage_attribution_table_unit #(
  parameter int ENTRIES = dat_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  dat_req_if.sink     req,
  dat_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import dat_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dat_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .stat     (stat),
    .in_ready (req.ready),
    .cmd      (cmd)
  );

  dat_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_data  (req.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_data  (rsp.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );

endmodule

// ----- design/dat_ctrl.sv -----
module dat_ctrl #(
  parameter int ENTRIES = dat_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  dat_pkg::stat_t stat,
  output logic          in_ready,
  output dat_pkg::cmd_t cmd
);
  import dat_pkg::*;

  localparam int DEPTH = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_TREE) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_req = 1'b1;
          state_next   = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match  = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_TREE;
      end
      ST_TREE: begin
        if (cnt == CNT_W'(DEPTH)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/dat_datapath.sv -----
`include "damage_attribution_table_unit_assert.svh"

module dat_datapath #(
  parameter int ENTRIES = dat_pkg::ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  dat_pkg::cmd_t  cmd,
  output dat_pkg::stat_t stat,
  input  dat_pkg::req_t  req_data,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  output dat_pkg::rsp_t  rsp_data,
  output logic           rsp_valid,
  input  logic           rsp_ready
);
  import dat_pkg::*;

  localparam int PTR_W  = $clog2(ENTRIES);
  localparam int LEAVES = 1 << PTR_W;
  localparam int NODES  = 2 * LEAVES;

  req_t        req_q;
  logic [31:0] window;
  logic [31:0] key   [ENTRIES];
  logic [31:0] sum   [ENTRIES];
  logic [31:0] stamp [ENTRIES];
  logic [PTR_W-1:0] ptr;
  logic [31:0] total;
  logic [ENTRIES-1:0] hit_oh;
  logic        hit_any;
  logic [31:0] found_q;
  logic [31:0] nsum [1:NODES-1];
  logic [31:0] nid  [1:NODES-1];

  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] first_vec;
  logic [ENTRIES-1:0] ptr_oh;
  logic [ENTRIES-1:0] we;
  logic [31:0] sel_sum;
  logic [31:0] found_next;
  logic        is_add;

  assign is_add    = (req_q.req_type == REQ_ADD);
  assign first_vec = match_vec & (~match_vec + ENTRIES'(1));

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cmp
    assign match_vec[i] = (key[i] == req_q.creature_id);
    assign ptr_oh[i]    = (ptr == PTR_W'(i));
    assign we[i]        = cmd.update && is_add && (hit_any ? hit_oh[i] : ptr_oh[i]);
  end

  always_comb begin
    sel_sum = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_sum = sel_sum | (hit_oh[i] ? sum[i] : 32'd0);
    end
  end

  always_comb begin
    if (is_add) begin
      found_next = hit_any ? sel_sum + req_q.amount : req_q.amount;
    end else begin
      found_next = hit_any ? sel_sum : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req_data;
    end
    if (rst) begin
      hit_oh  <= '0;
      hit_any <= 1'b0;
    end else if (cmd.match) begin
      hit_oh  <= first_vec;
      hit_any <= |match_vec;
    end
    if (cmd.update) begin
      found_q <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
      ptr    <= '0;
      total  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        key[i]   <= '0;
        sum[i]   <= '0;
        stamp[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      if (cmd.update && is_add) begin
        total <= total + req_q.amount;
        if (!hit_any) begin
          ptr <= (ptr == PTR_W'(ENTRIES - 1)) ? '0 : ptr + PTR_W'(1);
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (we[i]) begin
          key[i]   <= req_q.creature_id;
          sum[i]   <= hit_any ? sum[i] + req_q.amount : req_q.amount;
          stamp[i] <= req_q.now;
        end
      end
    end
  end

  // leaves of the max tree: recent nonzero entries, others read as zero
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < ENTRIES) begin : g_real
      logic [31:0] age;
      logic        cand;
      assign age  = req_q.now - stamp[j];
      assign cand = (age < window) && (sum[j] != 32'd0);
      always_ff @(posedge clk) begin
        nsum[LEAVES + j] <= cand ? sum[j] : 32'd0;
        nid[LEAVES + j]  <= cand ? key[j] : 32'd0;
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        nsum[LEAVES + j] <= '0;
        nid[LEAVES + j]  <= '0;
      end
    end
  end

  // ties keep the left child, the lower index
  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    always_ff @(posedge clk) begin
      if (nsum[2*k+1] > nsum[2*k]) begin
        nsum[k] <= nsum[2*k+1];
        nid[k]  <= nid[2*k+1];
      end else begin
        nsum[k] <= nsum[2*k];
        nid[k]  <= nid[2*k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data.found_amount    <= found_q;
      rsp_data.top_attacker_id <= nid[1];
      rsp_data.total_amount    <= total;
    end
  end

  assign stat.out_busy = rsp_valid && !rsp_ready;

  `DAT_ASSERT(a_we_onehot, $onehot0(we), "more than one entry written")
  `DAT_ASSERT(a_hit_onehot, $onehot0(hit_oh), "more than one hit selected")
  `DAT_ASSERT(a_ptr_range, ptr <= PTR_W'(ENTRIES - 1), "replace pointer out of range")
  `DAT_IMPLY(a_load_free, cmd.load_out, !stat.out_busy, "result overwritten while stalled")
  `DAT_NEXT(a_lookup_total, cmd.update && !is_add, $stable(total), "lookup changed total")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import dat_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;
  localparam int PHASE_ITEMS = 130;
  localparam int TAIL_CYCLES = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT = 200;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  dat_req_if req_ch ();
  dat_rsp_if rsp_ch ();

  damage_attribution_table_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the table
  logic [31:0] win_q;
  logic [31:0] key_q [SLOTS];
  logic [31:0] sum_q [SLOTS];
  logic [31:0] stamp_q [SLOTS];
  int          replace_q;
  logic [31:0] total_q;

  rsp_t        pending_rsp [$];
  int          errors = 0;
  int          rsp_count = 0;
  logic [31:0] id_pool [8];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic rsp_t attribute_damage(input req_t it);
    rsp_t        res;
    int          hit;
    logic [31:0] best;
    logic [31:0] age;
    res = '0;
    hit = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (key_q[i] == it.creature_id) hit = i;
    end
    if (it.req_type == REQ_ADD) begin
      total_q += it.amount;
      if (hit < 0) begin
        hit = replace_q;
        key_q[hit] = it.creature_id;
        sum_q[hit] = '0;
        replace_q = (replace_q + 1) % SLOTS;
      end
      sum_q[hit] += it.amount;
      stamp_q[hit] = it.now;
    end
    if (hit >= 0) res.found_amount = sum_q[hit];
    best = '0;
    for (int i = 0; i < SLOTS; i++) begin
      age = it.now - stamp_q[i];
      if (age < win_q && sum_q[i] > best) begin
        best = sum_q[i];
        res.top_attacker_id = key_q[i];
      end
    end
    res.total_amount = total_q;
    return res;
  endfunction

  function automatic stim_row_t row(input req_kind_t kind, input logic [31:0] id,
                                    input logic [31:0] amt, input logic [31:0] rnd,
                                    input bit typed, input logic [31:0] found,
                                    input logic [31:0] top, input logic [31:0] sum);
    stim_row_t r;
    r.item.req_type = kind;
    r.item.creature_id = id;
    r.item.amount = amt;
    r.item.now = rnd;
    r.typed = typed;
    r.want.found_amount = found;
    r.want.top_attacker_id = top;
    r.want.total_amount = sum;
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] got,
                        input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic push_item(input req_t it, input bit typed, input rsp_t want);
    rsp_t model;
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    do @(posedge clk); while (!req_ch.ready);
    model = attribute_damage(it);
    pending_rsp.push_back(typed ? want : model);
  endtask

  task automatic idle(input int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        report("unexpected item found_amount", rsp_ch.data.found_amount, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.data.found_amount !== want.found_amount)
          report("found_amount", rsp_ch.data.found_amount, want.found_amount);
        if (rsp_ch.data.top_attacker_id !== want.top_attacker_id)
          report("top_attacker_id", rsp_ch.data.top_attacker_id, want.top_attacker_id);
        if (rsp_ch.data.total_amount !== want.total_amount)
          report("total_amount", rsp_ch.data.total_amount, want.total_amount);
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int  seg;
    int  mode;
    bit  held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      seg = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        if (!held && rsp_count >= HOLD_AT) begin
          held = 1'b1;
          rsp_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            2: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
            3: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ch.ready <= 1'b1;
          endcase
        end
      end
    end
  end

  initial begin
    stim_row_t   dir_rows [$];
    req_t        it;
    logic [31:0] windows [6];
    logic [31:0] round_ctr;
    int          sent;
    int          burst;
    int          gap;
    int          pick;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    win_q = WINDOW_RESET;
    total_q = '0;
    replace_q = 0;
    for (int i = 0; i < SLOTS; i++) begin
      key_q[i] = '0;
      sum_q[i] = '0;
      stamp_q[i] = '0;
    end

    // cleared table, key zero, amount wrap, window edges, ties
    dir_rows.push_back(row(REQ_LOOKUP, 0, 32'hFFFFFFFF, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(REQ_ADD, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(REQ_ADD, 5, 32'hFFFFFFFF, 100, 1, 32'hFFFFFFFF, 5, 32'hFFFFFFFF));
    dir_rows.push_back(row(REQ_ADD, 5, 2, 150, 1, 1, 5, 1));
    dir_rows.push_back(row(REQ_LOOKUP, 0, 0, 150, 1, 0, 5, 1));
    dir_rows.push_back(row(REQ_LOOKUP, 5, 0, 209, 1, 1, 5, 1));
    dir_rows.push_back(row(REQ_LOOKUP, 5, 0, 210, 1, 1, 0, 1));
    dir_rows.push_back(row(REQ_LOOKUP, 5, 0, 149, 1, 1, 0, 1));
    dir_rows.push_back(row(REQ_ADD, 0, 7, 150, 0, 0, 0, 0));
    dir_rows.push_back(row(REQ_ADD, 32'hFFFFFFFF, 7, 151, 0, 0, 0, 0));
    dir_rows.push_back(row(REQ_ADD, 32'hA5A5A5A5, 7, 151, 0, 0, 0, 0));
    dir_rows.push_back(row(REQ_ADD, 32'h5A5A5A5A, 32'h80000000, 32'hFFFFFFFF, 0, 0, 0, 0));
    dir_rows.push_back(row(REQ_ADD, 32'h5A5A5A5A, 32'h80000000, 3, 0, 0, 0, 0));
    dir_rows.push_back(row(REQ_LOOKUP, 32'h12345678, 0, 32'hFFFFFFFF, 0, 0, 0, 0));
    // fill past the last entry so the replace pointer wraps
    for (int i = 0; i < 12; i++) begin
      dir_rows.push_back(row(REQ_ADD, 1000 + i, 10 * (i + 1), 300 + i, 0, 0, 0, 0));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    windows[0] = '0;
    windows[1] = 32'hFFFFFFFF;
    windows[2] = 32'd1;
    windows[3] = $urandom_range(2, 200);
    windows[4] = $urandom;
    windows[5] = WINDOW_RESET;
    round_ctr = 32'd1000;

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      cfg_we <= 1'b1;
      cfg_wdata <= windows[ph];
      @(posedge clk);
      cfg_we <= 1'b0;
      win_q = windows[ph];
      id_pool[0] = '0;
      for (int k = 1; k < 8; k++) begin
        id_pool[k] = (k < 5) ? $urandom_range(1, 40) : $urandom;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 20);
        if (burst > PHASE_ITEMS - sent) burst = PHASE_ITEMS - sent;
        repeat (burst) begin
          it.req_type = ($urandom_range(0, 9) < 7) ? REQ_ADD : REQ_LOOKUP;
          pick = $urandom_range(0, 9);
          if (pick < 7) it.creature_id = id_pool[$urandom_range(0, 7)];
          else if (pick == 7) it.creature_id = '0;
          else it.creature_id = $urandom;
          pick = $urandom_range(0, 19);
          if (pick < 12) it.amount = $urandom_range(0, 1000);
          else if (pick < 15) it.amount = '0;
          else if (pick < 18) it.amount = $urandom;
          else it.amount = 32'hFFFFFFFF - $urandom_range(0, 3);
          // rounds mostly advance slowly, sometimes jump or step back
          pick = $urandom_range(0, 19);
          if (pick < 17) round_ctr += $urandom_range(0, 8);
          else if (pick < 19) round_ctr = $urandom;
          else round_ctr -= $urandom_range(1, 4);
          it.now = round_ctr;
          push_item(it, 1'b0, '0);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) idle(gap);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/dat_pkg.sv
design/dat_intf.sv
design/dat_ctrl.sv
design/dat_datapath.sv
design/damage_attribution_table_unit.sv
tb/testbench.sv
